>>> design/celestial_to_cartesian_defines.svh
// Assertion macros for the celestial_to_cartesian checker.
// No dependencies; the names clk and arst_n must exist where a macro is used.
`ifndef CELESTIAL_TO_CARTESIAN_DEFINES_SVH
`define CELESTIAL_TO_CARTESIAN_DEFINES_SVH

// same-cycle implication
`define CTC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ctc assertion failed");

// next-cycle implication
`define CTC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ctc assertion failed");

`endif

>>> design/ctc_pkg.sv
// Shared types, constants and helper functions for the celestial_to_cartesian block.
// No dependencies.
`timescale 1ns / 1ps

package ctc_pkg;

	localparam int LANES           = 2;
	localparam int RA_W            = 21;
	localparam int DEC_W           = 20;
	localparam int RADIUS_W        = 16;
	localparam int COORD_W         = 17;
	localparam int ARCMIN_PER_TURN = 21600;
	localparam int COORD_FRAC_BITS = 8;
	localparam int RADIUS_RESET    = 50 << COORD_FRAC_BITS;
	localparam int HALF_PI_Q30     = 1686629713;
	localparam int COORD_MAX       = 65535;

	// quarter turn is QUARTER_ODD times a power of two; ceil(2^RECIP_SHIFT / QUARTER_ODD)
	// gives an exact floor division for every 32-bit dividend that occurs
	localparam int          QUARTER_ODD = 675;
	localparam int          RECIP_SHIFT = 41;
	localparam logic [31:0] RECIP_ODD   = 32'd3257812231;

	typedef logic signed [31:0] q30_t;

	localparam q30_t INV_GAIN_Q30 = 32'sd652032874;

	typedef enum logic [1:0] {
		QUAD_I,
		QUAD_II,
		QUAD_III,
		QUAD_IV
	} quad_t;

	typedef struct packed {
		q30_t c;
		q30_t s;
	} sincos_t;

	// atan(2^-i) in Q30, truncated
	function automatic q30_t atan_q30(input int idx);
		q30_t v;
		case (idx)
			0: v = 32'sd843314856;
			1: v = 32'sd497837829;
			2: v = 32'sd263043836;
			3: v = 32'sd133525158;
			4: v = 32'sd67021686;
			5: v = 32'sd33543515;
			6: v = 32'sd16775850;
			7: v = 32'sd8388437;
			8: v = 32'sd4194282;
			9: v = 32'sd2097149;
			10: v = 32'sd1048575;
			11: v = 32'sd524287;
			12: v = 32'sd262143;
			13: v = 32'sd131071;
			14: v = 32'sd65535;
			15: v = 32'sd32767;
			16: v = 32'sd16383;
			17: v = 32'sd8191;
			18: v = 32'sd4095;
			19: v = 32'sd2047;
			20: v = 32'sd1023;
			21: v = 32'sd511;
			22: v = 32'sd255;
			23: v = 32'sd127;
			default: v = '0;
		endcase
		return v;
	endfunction

	// fold first-quadrant cos/sin out to the full circle
	function automatic sincos_t apply_quad(input q30_t x, input q30_t y, input quad_t q);
		sincos_t r;
		case (q)
			QUAD_I: begin
				r.c = x;
				r.s = y;
			end
			QUAD_II: begin
				r.c = -y;
				r.s = x;
			end
			QUAD_III: begin
				r.c = -x;
				r.s = -y;
			end
			default: begin
				r.c = y;
				r.s = -x;
			end
		endcase
		return r;
	endfunction

endpackage

>>> design/ctc_cdiv.sv
// Two-lane pipelined restoring divider by a constant, one quotient bit per stage.
// Depends on ctc_pkg.
`timescale 1ns / 1ps

module ctc_cdiv #(
	parameter int DW  = 21,
	parameter int QW  = 5,
	parameter int DIV = 86400,
	parameter int PW  = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [DW-1:0]              in_num [ctc_pkg::LANES],
	input  logic [PW-1:0]              in_pay,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [QW-1:0]              out_quo [ctc_pkg::LANES],
	output logic [$clog2(DIV)-1:0]     out_rem [ctc_pkg::LANES],
	output logic [PW-1:0]              out_pay
);
	import ctc_pkg::*;

	localparam int RW = $clog2(DIV);
	localparam logic [RW:0] DIV_W = (RW+1)'(DIV);

	logic          v_s   [QW];
	logic [RW-1:0] rem_s [QW][LANES];
	logic [QW-1:0] sh_s  [QW][LANES];
	logic [PW-1:0] pay_s [QW];
	logic          rdy   [QW+1];

	assign rdy[QW] = out_ready;
	assign in_ready = rdy[0];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic          src_v;
		logic [RW-1:0] src_rem [LANES];
		logic [QW-1:0] src_sh  [LANES];
		logic [PW-1:0] src_pay;
		logic [RW-1:0] nxt_rem [LANES];
		logic [QW-1:0] nxt_sh  [LANES];

		if (k == 0) begin : g_first
			always_comb begin
				src_v = in_valid;
				src_pay = in_pay;
				for (int l = 0; l < LANES; l++) begin
					src_rem[l] = RW'(in_num[l] >> QW);
					src_sh[l] = QW'(in_num[l]);
				end
			end
		end else begin : g_next
			always_comb begin
				src_v = v_s[k-1];
				src_pay = pay_s[k-1];
				for (int l = 0; l < LANES; l++) begin
					src_rem[l] = rem_s[k-1][l];
					src_sh[l] = sh_s[k-1][l];
				end
			end
		end

		// shift in the next dividend bit, quotient bit enters at the bottom
		always_comb begin
			logic [RW:0] tmp;
			logic        ge;
			for (int l = 0; l < LANES; l++) begin
				tmp = {src_rem[l], src_sh[l][QW-1]};
				ge = (tmp >= DIV_W);
				nxt_rem[l] = ge ? RW'(tmp - DIV_W) : RW'(tmp);
				nxt_sh[l] = QW'({src_sh[l], ge});
			end
		end

		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				pay_s[k] <= src_pay;
				for (int l = 0; l < LANES; l++) begin
					rem_s[k][l] <= nxt_rem[l];
					sh_s[k][l] <= nxt_sh[l];
				end
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign out_pay = pay_s[QW-1];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			out_quo[l] = sh_s[QW-1][l];
			out_rem[l] = rem_s[QW-1][l];
		end
	end

endmodule

>>> design/ctc_cordic.sv
// Two-lane unrolled rotation-mode CORDIC, one micro-rotation per pipeline stage.
// Depends on ctc_pkg (Q30 type, gain and arctangent table).
`timescale 1ns / 1ps

module ctc_cordic #(
	parameter int STAGES = 16,
	parameter int PW     = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ctc_pkg::q30_t in_theta [ctc_pkg::LANES],
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	input  logic          out_ready,
	output ctc_pkg::q30_t out_x [ctc_pkg::LANES],
	output ctc_pkg::q30_t out_y [ctc_pkg::LANES],
	output logic [PW-1:0] out_pay
);
	import ctc_pkg::*;

	logic          v_s   [STAGES];
	q30_t          x_s   [STAGES][LANES];
	q30_t          y_s   [STAGES][LANES];
	q30_t          z_s   [STAGES][LANES];
	logic [PW-1:0] pay_s [STAGES];
	logic          rdy   [STAGES+1];

	assign rdy[STAGES] = out_ready;
	assign in_ready = rdy[0];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam q30_t ATAN = atan_q30(k);

		logic          src_v;
		q30_t          src_x [LANES];
		q30_t          src_y [LANES];
		q30_t          src_z [LANES];
		logic [PW-1:0] src_pay;
		q30_t          nxt_x [LANES];
		q30_t          nxt_y [LANES];
		q30_t          nxt_z [LANES];

		if (k == 0) begin : g_first
			always_comb begin
				src_v = in_valid;
				src_pay = in_pay;
				for (int l = 0; l < LANES; l++) begin
					src_x[l] = INV_GAIN_Q30;
					src_y[l] = '0;
					src_z[l] = in_theta[l];
				end
			end
		end else begin : g_next
			always_comb begin
				src_v = v_s[k-1];
				src_pay = pay_s[k-1];
				for (int l = 0; l < LANES; l++) begin
					src_x[l] = x_s[k-1][l];
					src_y[l] = y_s[k-1][l];
					src_z[l] = z_s[k-1][l];
				end
			end
		end

		always_comb begin
			q30_t dx;
			q30_t dy;
			for (int l = 0; l < LANES; l++) begin
				dx = src_y[l] >>> k;
				dy = src_x[l] >>> k;
				if (!src_z[l][31]) begin
					nxt_x[l] = src_x[l] - dx;
					nxt_y[l] = src_y[l] + dy;
					nxt_z[l] = src_z[l] - ATAN;
				end else begin
					nxt_x[l] = src_x[l] + dx;
					nxt_y[l] = src_y[l] - dy;
					nxt_z[l] = src_z[l] + ATAN;
				end
			end
		end

		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				pay_s[k] <= src_pay;
				for (int l = 0; l < LANES; l++) begin
					x_s[k][l] <= nxt_x[l];
					y_s[k][l] <= nxt_y[l];
					z_s[k][l] <= nxt_z[l];
				end
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign out_pay = pay_s[STAGES-1];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			out_x[l] = x_s[STAGES-1][l];
			out_y[l] = y_s[STAGES-1][l];
		end
	end

endmodule

>>> design/ctc_scale.sv
// Output math: quadrant fold, cos*cos and sin*cos products, radius scaling, rounding
// and saturation. Three stages, the last is the output register. Depends on ctc_pkg.
`timescale 1ns / 1ps

module ctc_scale (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  ctc_pkg::q30_t                   in_c    [ctc_pkg::LANES],
	input  ctc_pkg::q30_t                   in_s    [ctc_pkg::LANES],
	input  ctc_pkg::quad_t                  in_quad [ctc_pkg::LANES],
	input  logic                            in_last,
	input  logic [ctc_pkg::RADIUS_W-1:0]    radius,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ctc_pkg::COORD_W-1:0]     out_x,
	output logic [ctc_pkg::COORD_W-1:0]     out_y,
	output logic [ctc_pkg::COORD_W-1:0]     out_z,
	output logic                            out_last
);
	import ctc_pkg::*;

	localparam int PROD_W = RADIUS_W + 1 + 32;

	function automatic q30_t round_q60(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + 64'sd536870912;
		return 32'(t >>> 30);
	endfunction

	function automatic logic [COORD_W-1:0] round_sat(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		logic signed [PROD_W-1:0] r;
		logic [COORD_W-1:0]       o;
		t = v + PROD_W'(64'sd536870912);
		r = t >>> 30;
		if (r > PROD_W'(COORD_MAX)) begin
			o = COORD_W'(COORD_MAX);
		end else if (r < -PROD_W'(COORD_MAX)) begin
			o = COORD_W'(-COORD_MAX);
		end else begin
			o = r[COORD_W-1:0];
		end
		return o;
	endfunction

	logic                     v_s1, v_s2, v_s3;
	logic                     rdy1, rdy2, rdy3;
	logic signed [63:0]       pcc_s1, psc_s1;
	q30_t                     sdec_s1;
	logic                     last_s1, last_s2, last_s3;
	logic signed [PROD_W-1:0] px_s2, py_s2, pz_s2;
	logic [COORD_W-1:0]       x_s3, y_s3, z_s3;

	sincos_t ra_cs, dec_cs;
	logic signed [RADIUS_W:0] rad_s;

	assign ra_cs = apply_quad(in_c[0], in_s[0], in_quad[0]);
	assign dec_cs = apply_quad(in_c[1], in_s[1], in_quad[1]);
	assign rad_s = $signed({1'b0, radius});

	assign rdy3 = !v_s3 || out_ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			pcc_s1 <= 64'(ra_cs.c) * 64'(dec_cs.c);
			psc_s1 <= 64'(ra_cs.s) * 64'(dec_cs.c);
			sdec_s1 <= dec_cs.s;
			last_s1 <= in_last;
		end
		if (rdy2) begin
			px_s2 <= rad_s * round_q60(pcc_s1);
			py_s2 <= rad_s * sdec_s1;
			pz_s2 <= rad_s * round_q60(psc_s1);
			last_s2 <= last_s1;
		end
		if (rdy3) begin
			x_s3 <= round_sat(px_s2);
			y_s3 <= round_sat(py_s2);
			z_s3 <= round_sat(pz_s2);
			last_s3 <= last_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_x = x_s3;
	assign out_y = y_s3;
	assign out_z = z_s3;
	assign out_last = last_s3;

endmodule

>>> design/celestial_to_cartesian.sv
// Celestial (RA/Dec) to Cartesian converter, top level.
// Instantiates ctc_cdiv, ctc_cordic and ctc_scale; depends on ctc_pkg.
//
// Takes one point per clock cycle while the output side accepts results. The pipeline
// is the one-bit-per-stage angle reduction (quotient width QW1), two stages of
// radian scaling (reciprocal multiply), the unrolled CORDIC and three stages of
// output math. Every stage has its own valid bit and moves whenever the stage ahead
// is empty or moving, so a waiting result closes the input only once every stage
// holds an item, and nothing is lost or repeated under backpressure. The radius
// register may only be written while the pipeline is empty.
`timescale 1ns / 1ps

module celestial_to_cartesian #(
	parameter int ANGLE_FRAC_BITS = 6,
	parameter int CORDIC_STAGES   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,       // sphere_radius
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,         // ra_arcmin[20:0], dec_arcmin[40:21]
	input  logic        s_tlast,         // last_point
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,         // x_pos[16:0], y_pos[33:17], z_pos[50:34]
	output logic        m_tlast          // last_out
);
	import ctc_pkg::*;

	localparam int QUARTER   = (ARCMIN_PER_TURN << ANGLE_FRAC_BITS) / 4;
	localparam int RW        = $clog2(QUARTER);
	localparam int QW1_RAW   = $clog2((2 ** RA_W) / QUARTER + 1);
	localparam int QW1       = (QW1_RAW > 0) ? QW1_RAW : 1;
	localparam int VW        = 2 * RW;
	localparam int CO_A      = HALF_PI_Q30 / QUARTER;
	localparam int CO_B      = HALF_PI_Q30 % QUARTER;
	localparam int DIV_SHIFT = $clog2(QUARTER / QUARTER_ODD);
	localparam int PW3       = 1 + 2 * LANES;
	localparam logic [RW:0] QUARTER_W = (RW+1)'(QUARTER);

	// radius register
	logic [RADIUS_W-1:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_W'(RADIUS_RESET);
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// angle reduction: quadrant and remainder of both angles
	logic [DEC_W-1:0] dec_raw;
	logic             dec_neg;
	logic [RA_W-1:0]  dec_mag;
	logic [RA_W-1:0]  div1_num [LANES];
	logic             div1_v, div1_rdy;
	logic [QW1-1:0]   div1_quo [LANES];
	logic [RW-1:0]    div1_rem [LANES];
	logic [1:0]       div1_pay;

	assign dec_raw = s_tdata[RA_W +: DEC_W];
	assign dec_neg = dec_raw[DEC_W-1];
	assign dec_mag = RA_W'((RA_W+1)'(1 << DEC_W) - (RA_W+1)'(dec_raw));
	assign div1_num[0] = s_tdata[RA_W-1:0];
	assign div1_num[1] = dec_neg ? dec_mag : RA_W'(dec_raw);

	ctc_cdiv #(
		.DW  (RA_W),
		.QW  (QW1),
		.DIV (QUARTER),
		.PW  (2)
	) u_div_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_num    (div1_num),
		.in_pay    ({s_tlast, dec_neg}),
		.out_valid (div1_v),
		.out_ready (div1_rdy),
		.out_quo   (div1_quo),
		.out_rem   (div1_rem),
		.out_pay   (div1_pay)
	);

	// fold negative declination, split radian scaling into m*A + (m*B + Q/2)/Q
	quad_t         quad_c [LANES];
	logic [RW-1:0] m_c    [LANES];

	always_comb begin
		logic [1:0] q2;
		q2 = 2'(div1_quo[0]);
		quad_c[0] = quad_t'(q2);
		m_c[0] = div1_rem[0];
		q2 = 2'(div1_quo[1]);
		if (!div1_pay[0]) begin
			quad_c[1] = quad_t'(q2);
			m_c[1] = div1_rem[1];
		end else if (div1_rem[1] == '0) begin
			quad_c[1] = quad_t'(~q2 + 2'd1);
			m_c[1] = '0;
		end else begin
			quad_c[1] = quad_t'(~q2);
			m_c[1] = RW'(QUARTER_W - {1'b0, div1_rem[1]});
		end
	end

	logic          v_s1, rdy_s1;
	quad_t         quad_s1 [LANES];
	logic [VW-1:0] num_s1  [LANES];
	logic [31:0]   ma_s1   [LANES];
	logic          last_s1;
	logic          rdy_s2;

	assign rdy_s1 = !v_s1 || rdy_s2;
	assign div1_rdy = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= div1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			last_s1 <= div1_pay[1];
			for (int l = 0; l < LANES; l++) begin
				quad_s1[l] <= quad_c[l];
				num_s1[l] <= VW'(m_c[l]) * VW'(CO_B) + VW'(QUARTER / 2);
				ma_s1[l] <= 32'(m_c[l]) * 32'(CO_A);
			end
		end
	end

	// (m*B + Q/2) / Q: drop the power-of-two factor of Q, then multiply by 1/675
	logic          v_s2;
	quad_t         quad_s2 [LANES];
	logic [63:0]   prod_s2 [LANES];
	logic [31:0]   ma_s2   [LANES];
	logic          last_s2;
	logic          cor_in_rdy;

	assign rdy_s2 = !v_s2 || cor_in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			last_s2 <= last_s1;
			for (int l = 0; l < LANES; l++) begin
				quad_s2[l] <= quad_s1[l];
				ma_s2[l] <= ma_s1[l];
				prod_s2[l] <= 64'(32'(num_s1[l] >> DIV_SHIFT)) * 64'(RECIP_ODD);
			end
		end
	end

	q30_t theta [LANES];

	assign theta[0] = q30_t'(ma_s2[0] + 32'(prod_s2[0] >> RECIP_SHIFT));
	assign theta[1] = q30_t'(ma_s2[1] + 32'(prod_s2[1] >> RECIP_SHIFT));

	logic           cor_v, cor_rdy;
	q30_t           cor_x [LANES];
	q30_t           cor_y [LANES];
	logic [PW3-1:0] cor_pay;

	ctc_cordic #(
		.STAGES (CORDIC_STAGES),
		.PW     (PW3)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (cor_in_rdy),
		.in_theta  (theta),
		.in_pay    ({last_s2, quad_s2[1], quad_s2[0]}),
		.out_valid (cor_v),
		.out_ready (cor_rdy),
		.out_x     (cor_x),
		.out_y     (cor_y),
		.out_pay   (cor_pay)
	);

	quad_t cor_quad [LANES];

	assign cor_quad[0] = quad_t'(cor_pay[1:0]);
	assign cor_quad[1] = quad_t'(cor_pay[3:2]);

	logic [COORD_W-1:0] x_pos, y_pos, z_pos;

	ctc_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cor_v),
		.in_ready  (cor_rdy),
		.in_c      (cor_x),
		.in_s      (cor_y),
		.in_quad   (cor_quad),
		.in_last   (cor_pay[4]),
		.radius    (radius_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_x     (x_pos),
		.out_y     (y_pos),
		.out_z     (z_pos),
		.out_last  (m_tlast)
	);

	assign m_tdata = {5'd0, z_pos, y_pos, x_pos};

endmodule

>>> design/ctc_checker.sv
// Port-level checker for celestial_to_cartesian, bound to the top level.
// Depends on celestial_to_cartesian_defines.svh.
`timescale 1ns / 1ps
`include "celestial_to_cartesian_defines.svh"

module ctc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tlast
);

	logic [16:0] x_c, y_c, z_c;

	assign x_c = m_tdata[16:0];
	assign y_c = m_tdata[33:17];
	assign z_c = m_tdata[50:34];

	`CTC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`CTC_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
	// empty output implies every stage can move, so the input is open
	`CTC_ASSERT_NOW(a_in_open, !m_tvalid, s_tready)
	// saturation keeps -65536 out and the pad bits stay clear
	`CTC_ASSERT_NOW(a_sat_range, m_tvalid, (x_c != 17'h10000) && (y_c != 17'h10000) && (z_c != 17'h10000))
	`CTC_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[55:51] == 5'd0)

endmodule

bind celestial_to_cartesian ctc_checker u_ctc_checker (.*);

>>> test/celestial_to_cartesian_tb.sv
// Self-checking testbench for celestial_to_cartesian: random and directed points go in over
// the input stream, and each output point is compared with a fixed-point CORDIC predictor.
// Depends on ctc_pkg and the celestial_to_cartesian RTL.
`timescale 1ns / 1ps

module celestial_to_cartesian_tb;
	import ctc_pkg::*;

	localparam int ANGLE_FRAC_BITS = 6;
	localparam int CORDIC_STAGES   = 16;
	localparam longint FULL_TURN   = longint'(ARCMIN_PER_TURN) << ANGLE_FRAC_BITS;
	localparam longint QUARTER     = FULL_TURN / 4;
	localparam int RAND_PER_PHASE  = 130;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 100;
	localparam int CYCLE_LIMIT     = 400000;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      last;
	} xyz_t;

	class coord_scoreboard;
		xyz_t   pending_q[$];
		longint radius;
		int     errors;

		function new();
			radius = RADIUS_RESET;
			errors = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("celestial_to_cartesian_tb: %s", msg);
		endfunction

		function longint atan_step(int i);
			case (i)
				0: return 843314856;
				1: return 497837829;
				2: return 263043836;
				3: return 133525158;
				4: return 67021686;
				5: return 33543515;
				6: return 16775850;
				7: return 8388437;
				8: return 4194282;
				9: return 2097149;
				10: return 1048575;
				11: return 524287;
				12: return 262143;
				13: return 131071;
				14: return 65535;
				default: return 32767;
			endcase
		endfunction

		function longint round30(longint v);
			return (v + 64'sd536870912) >>> 30;
		endfunction

		// a in [0, FULL_TURN)
		function void sin_cos(longint a, output longint c, output longint s);
			longint m, x, y, z, dx, dy;
			logic [1:0] qbits;
			quad_t q;
			qbits = 2'((a / QUARTER) % 4);
			q = quad_t'(qbits);
			m = a % QUARTER;
			z = (m * longint'(HALF_PI_Q30) + QUARTER / 2) / QUARTER;
			x = longint'(INV_GAIN_Q30);
			y = 0;
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - atan_step(i);
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + atan_step(i);
				end
			end
			case (q)
				QUAD_I: begin
					c = x;
					s = y;
				end
				QUAD_II: begin
					c = -y;
					s = x;
				end
				QUAD_III: begin
					c = -x;
					s = -y;
				end
				default: begin
					c = y;
					s = -x;
				end
			endcase
		endfunction

		function logic signed [COORD_W-1:0] to_coord(longint f);
			longint v;
			v = round30(radius * f);
			if (v > COORD_MAX)
				v = COORD_MAX;
			if (v < -COORD_MAX)
				v = -COORD_MAX;
			return v[COORD_W-1:0];
		endfunction

		function void note_point(logic [RA_W-1:0] ra, logic [DEC_W-1:0] dec, logic last);
			longint a_ra, a_dec, mag, c_ra, s_ra, c_dec, s_dec;
			xyz_t e;
			a_ra = longint'(ra) % FULL_TURN;
			if (dec[DEC_W-1]) begin
				mag = (64'sd1048576 - longint'(dec)) % FULL_TURN;
				a_dec = (mag != 0) ? FULL_TURN - mag : 0;
			end else begin
				a_dec = longint'(dec) % FULL_TURN;
			end
			sin_cos(a_ra, c_ra, s_ra);
			sin_cos(a_dec, c_dec, s_dec);
			e.x = to_coord(round30(c_ra * c_dec));
			e.y = to_coord(s_dec);
			e.z = to_coord(round30(s_ra * c_dec));
			e.last = last;
			pending_q.push_back(e);
		endfunction

		function void check_point(xyz_t got);
			xyz_t e;
			if (pending_q.size() == 0) begin
				flag("output item with no input pending");
				return;
			end
			e = pending_q.pop_front();
			if (got.x !== e.x)
				flag($sformatf("x_pos mismatch: expected %0d, got %0d", e.x, got.x));
			if (got.y !== e.y)
				flag($sformatf("y_pos mismatch: expected %0d, got %0d", e.y, got.y));
			if (got.z !== e.z)
				flag($sformatf("z_pos mismatch: expected %0d, got %0d", e.z, got.z));
			if (got.last !== e.last)
				flag($sformatf("last_out mismatch: expected %0b, got %0b", e.last, got.last));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        m_tlast;

	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;
	int cycle_count = 0;

	coord_scoreboard sb = new();

	celestial_to_cartesian #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.CORDIC_STAGES  (CORDIC_STAGES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("celestial_to_cartesian_tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_point(s_tdata[20:0], s_tdata[40:21], s_tlast);
			if (m_tvalid && m_tready)
				sb.check_point({m_tdata[16:0], m_tdata[33:17], m_tdata[50:34], m_tlast});
		end
	end

	// output side: random stalls, ready stretches, one long hold-off on request
	initial begin
		int r;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			r = $urandom_range(99, 0);
			if (r < 60) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(8, 1)) @(posedge clk);
			end else if (r < 70) begin
				m_tready <= 1'b1;
				repeat (40) @(posedge clk);
			end else if (r < 95) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(3, 1)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(40, 5)) @(posedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 5);
	endfunction

	function automatic logic [RA_W-1:0] rand_ra();
		int sel, v;
		sel = $urandom_range(9, 0);
		if (sel < 6)
			v = $urandom_range(int'(FULL_TURN) - 1, 0);
		else if (sel == 6)
			v = int'($urandom_range(4, 0)) * int'(QUARTER) + int'($urandom_range(4, 0)) - 2;
		else
			v = $urandom();
		return v[RA_W-1:0];
	endfunction

	function automatic logic [DEC_W-1:0] rand_dec();
		int sel, v;
		sel = $urandom_range(9, 0);
		if (sel < 6)
			v = int'($urandom_range(2 * int'(QUARTER), 0)) - int'(QUARTER);
		else if (sel == 6)
			v = (int'($urandom_range(2, 0)) - 1) * int'(QUARTER) + int'($urandom_range(4, 0)) - 2;
		else
			v = $urandom();
		return v[DEC_W-1:0];
	endfunction

	task automatic send_item(input longint ra, input longint dec, input logic last, input int gap);
		logic [RA_W-1:0] ra_bits;
		logic [DEC_W-1:0] dec_bits;
		ra_bits = ra[RA_W-1:0];
		dec_bits = dec[DEC_W-1:0];
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, dec_bits, ra_bits};
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic run_random(input bit with_hold);
		int gap;
		for (int i = 0; i < RAND_PER_PHASE; i++) begin
			gap = ((i % 64) < 16) ? 0 : pick_gap();
			if (with_hold && i == 40)
				hold_req = 1'b1;
			send_item(rand_ra(), rand_dec(), ($urandom_range(7, 0) == 0), gap);
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_radius(input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.radius = v;
	endtask

	// the random phase that follows takes over the input stream without a gap
	task automatic run_directed();
		send_item(0, 0, 1'b0, 0);
		send_item(QUARTER, 0, 1'b1, 0);
		send_item(2 * QUARTER, 0, 1'b0, 0);
		send_item(3 * QUARTER, 0, 1'b0, 1);
		send_item(FULL_TURN - 1, 0, 1'b0, 0);
		send_item(FULL_TURN, 0, 1'b0, 0);
		send_item(longint'(21'h1FFFFF), 0, 1'b1, 2);
		send_item(0, QUARTER, 1'b0, 0);
		send_item(0, -QUARTER, 1'b0, 0);
		send_item(0, 524287, 1'b0, 0);
		send_item(0, -524288, 1'b1, 0);
		send_item(0, 1, 1'b0, 0);
		send_item(0, -1, 1'b0, 3);
		send_item(QUARTER - 1, QUARTER / 2, 1'b0, 0);
		send_item(1, -QUARTER / 2, 1'b0, 0);
		send_item(FULL_TURN + QUARTER, QUARTER - 1, 1'b0, 0);
		send_item(QUARTER + 1, -QUARTER + 1, 1'b1, 0);
	endtask

	initial begin
		logic [15:0] radius_plan[7];
		radius_plan = '{16'hFFFF, 16'd0, 16'd1, 16'd256, 16'd0, 16'h8000, 16'd12800};
		radius_plan[4] = $urandom_range(65534, 2);
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		run_directed();
		run_random(1'b0);
		drain();
		for (int p = 0; p < 7; p++) begin
			write_radius(radius_plan[p]);
			if (p == 0) begin
				// full-scale radius: CORDIC overshoot must clamp
				for (int k = 0; k < 4; k++)
					send_item(k * QUARTER, 0, (k == 3), 0);
				send_item(0, QUARTER, 1'b0, 0);
				send_item(0, -QUARTER, 1'b0, 0);
			end
			run_random(p == 4);
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_q.size() != 0)
			sb.flag($sformatf("%0d expected results never arrived", sb.pending_q.size()));
		if (sb.errors == 0)
			$display("celestial_to_cartesian_tb: done, clean");
		else
			$display("celestial_to_cartesian_tb: done, errors");
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/ctc_pkg.sv
design/ctc_cdiv.sv
design/ctc_cordic.sv
design/ctc_scale.sv
design/celestial_to_cartesian.sv
design/ctc_checker.sv
test/celestial_to_cartesian_tb.sv
